// ===== rtl/core/binary_min_heap_queue_macros.svh =====
// Assertion macros for the binary min-heap queue.
// Uses clk and arst_n of the including module; no other dependencies.
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// plain property, sampled on clk, off during reset
`define BMHQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication, sampled on clk, off during reset
`define BMHQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Shared types and constants of the binary min-heap queue.
// No dependencies; used by bmhq_store and binary_min_heap_queue.
`default_nettype none

package bmhq_pkg;

	localparam int ID_W      = 16;
	localparam int WT_W      = 32;
	localparam int ACT_W     = 2;
	localparam int CNT_OUT_W = 7;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 64;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [WT_W-1:0] wt;
	} entry_t;

	typedef enum logic [1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_REM = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_UP_RD,
		FSM_UP_CMP,
		FSM_DN_RD,
		FSM_DN_CMP,
		FSM_DEQ_LD,
		FSM_SRCH,
		FSM_RM_LD,
		FSM_PLACE,
		FSM_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmhq_store.sv =====
// Heap entry storage: one write port, two read ports with registered data.
// Depends on bmhq_pkg for entry_t.
`default_nettype none

module bmhq_store #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       wa,
	input  bmhq_pkg::entry_t    wd,
	input  logic [AW-1:0]       ra,
	input  logic [AW-1:0]       rb,
	output bmhq_pkg::entry_t    rda,
	output bmhq_pkg::entry_t    rdb
);
	import bmhq_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rda <= mem[ra];
		rdb <= mem[rb];
	end

endmodule

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue.sv =====
// Top level of the binary min-heap queue: sequencer, sift datapath, result register.
// Depends on bmhq_pkg, bmhq_store and binary_min_heap_queue_macros.svh.
//
// channel  dir  tdata                          tuser
// s_*      in   [15:0] node_id, [47:16] weight [1:0] action
// m_*      out  [15:0] out_id, [47:16] out_weight, [49:48] status, [56:50] entry_count
//
// Enqueue sifts the new entry up from the next free slot, or places it at the root when empty;
// dequeue takes the root as result and sifts the last entry down from the root, unless it was the last;
// remove scans for the id (not found if absent), moves the last entry into the hole unless the match
// was last, sifts up, then down as dequeue. Empty, full and unused-code items go to done. One item at a time.
// Reset clears the control state, the count and the output valid; storage and payload are never cleared.
// A result waits in the output register; the sequencer holds in done until it frees.
`default_nettype none
`include "binary_min_heap_queue_macros.svh"

module binary_min_heap_queue #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bmhq_pkg::S_DATA_W-1:0] s_tdata,   // [15:0] node_id, [47:16] weight
	input  logic [bmhq_pkg::ACT_W-1:0]    s_tuser,   // [1:0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bmhq_pkg::M_DATA_W-1:0] m_tdata    // [15:0] out_id, [47:16] out_weight,
	                                                 // [49:48] status, [56:50] entry_count
);
	import bmhq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = IW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam int PAD_W = M_DATA_W - CNT_OUT_W - 2 - WT_W - ID_W;

	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    hole_q;
	entry_t           mv_q;
	logic [ID_W-1:0]  rm_id_q;
	logic             down_q;
	logic [CW-1:0]    scan_q;
	logic             vld_s1;
	logic [IW-1:0]    idx_s1;
	entry_t           res_q;
	status_t          stat_q;
	logic             out_vld_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic             we;
	logic [IW-1:0]    wa, ra, rb;
	entry_t           wd, rda, rdb;

	action_t          act;
	logic             accept, full, empty, out_free;
	logic [XW-1:0]    lch, rch, cnt_x;
	logic [IW-1:0]    par, last_idx;
	logic             up_swap, l_ok, r_ok, pick_l, pick_r, hit, scan_more;
	logic [WT_W-1:0]  best_l_w;

	bmhq_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk (clk),
		.we  (we),
		.wa  (wa),
		.wd  (wd),
		.ra  (ra),
		.rb  (rb),
		.rda (rda),
		.rdb (rdb)
	);

	assign act       = action_t'(s_tuser);
	assign s_tready  = (state_q == FSM_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign full      = (cnt_q == CAP_C);
	assign empty     = (cnt_q == '0);
	assign out_free  = !out_vld_q || m_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_data_q;

	assign lch       = {1'b0, hole_q, 1'b1};
	assign rch       = lch + XW'(1);
	assign cnt_x     = XW'(cnt_q);
	assign par       = IW'((hole_q - IW'(1)) >> 1);
	assign last_idx  = IW'(cnt_q - CW'(1));
	assign up_swap   = rda.wt > mv_q.wt;
	assign l_ok      = lch < cnt_x;
	assign r_ok      = rch < cnt_x;
	assign best_l_w  = (l_ok && (rda.wt < mv_q.wt)) ? rda.wt : mv_q.wt;
	assign pick_r    = r_ok && (rdb.wt < best_l_w);
	assign pick_l    = !pick_r && l_ok && (rda.wt < mv_q.wt);
	assign hit       = vld_s1 && (rda.id == rm_id_q);
	assign scan_more = scan_q < cnt_q;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		wa      = hole_q;
		wd      = mv_q;
		ra      = lch[IW-1:0];
		rb      = rch[IW-1:0];
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (act)
						ACT_ENQ: begin
							if (full) begin
								state_d = FSM_DONE;
							end else if (empty) begin
								state_d = FSM_PLACE;
							end else begin
								state_d = FSM_UP_RD;
							end
						end
						ACT_DEQ: begin
							ra      = '0;
							rb      = last_idx;
							state_d = empty ? FSM_DONE : FSM_DEQ_LD;
						end
						ACT_REM: state_d = empty ? FSM_DONE : FSM_SRCH;
						ACT_NOP: state_d = FSM_DONE;
					endcase
				end
			end
			FSM_UP_RD: begin
				ra      = par;
				state_d = FSM_UP_CMP;
			end
			FSM_UP_CMP: begin
				if (up_swap) begin
					we = 1'b1;
					wd = rda;
					if (par != '0) begin
						state_d = FSM_UP_RD;
					end else begin
						state_d = down_q ? FSM_DN_RD : FSM_PLACE;
					end
				end else begin
					state_d = down_q ? FSM_DN_RD : FSM_PLACE;
				end
			end
			FSM_DN_RD: state_d = l_ok ? FSM_DN_CMP : FSM_PLACE;
			FSM_DN_CMP: begin
				priority if (pick_r) begin
					we      = 1'b1;
					wd      = rdb;
					state_d = FSM_DN_RD;
				end else if (pick_l) begin
					we      = 1'b1;
					wd      = rda;
					state_d = FSM_DN_RD;
				end else begin
					state_d = FSM_PLACE;
				end
			end
			FSM_DEQ_LD: state_d = empty ? FSM_DONE : FSM_DN_RD;
			FSM_SRCH: begin
				ra = scan_q[IW-1:0];
				if (hit) begin
					ra      = last_idx;
					state_d = (idx_s1 == last_idx) ? FSM_DONE : FSM_RM_LD;
				end else if (!vld_s1 && !scan_more) begin
					state_d = FSM_DONE;
				end
			end
			FSM_RM_LD: state_d = (hole_q == '0) ? FSM_DN_RD : FSM_UP_RD;
			FSM_PLACE: begin
				we      = 1'b1;
				state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			cnt_q     <= '0;
			down_q    <= 1'b0;
			scan_q    <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				down_q <= (act == ACT_REM);
				scan_q <= '0;
				vld_s1 <= 1'b0;
				if (act == ACT_ENQ && !full) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (act == ACT_DEQ && !empty) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (state_q == FSM_SRCH) begin
				vld_s1 <= scan_more && !hit;
				if (scan_more) begin
					scan_q <= scan_q + CW'(1);
				end
				if (hit) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (state_q == FSM_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mv_q    <= '{id: s_tdata[ID_W-1:0], wt: s_tdata[ID_W +: WT_W]};
			rm_id_q <= s_tdata[ID_W-1:0];
			hole_q  <= (act == ACT_ENQ) ? cnt_q[IW-1:0] : '0;
			res_q   <= '0;
			unique case (act)
				ACT_ENQ: stat_q <= full ? STAT_FULL : STAT_OK;
				ACT_DEQ: stat_q <= empty ? STAT_EMPTY : STAT_OK;
				ACT_REM: stat_q <= empty ? STAT_NOT_FOUND : STAT_OK;
				ACT_NOP: stat_q <= STAT_OK;
			endcase
		end
		unique case (state_q)
			FSM_UP_CMP: begin
				if (up_swap) begin
					hole_q <= par;
				end
			end
			FSM_DN_CMP: begin
				priority if (pick_r) begin
					hole_q <= rch[IW-1:0];
				end else if (pick_l) begin
					hole_q <= lch[IW-1:0];
				end
			end
			FSM_DEQ_LD: begin
				res_q <= rda;
				mv_q  <= rdb;
			end
			FSM_SRCH: begin
				idx_s1 <= scan_q[IW-1:0];
				if (hit) begin
					hole_q <= idx_s1;
				end else if (!vld_s1 && !scan_more) begin
					stat_q <= STAT_NOT_FOUND;
				end
			end
			FSM_RM_LD: mv_q <= rda;
			FSM_DONE: begin
				if (out_free) begin
					out_data_q <= {{PAD_W{1'b0}}, CNT_OUT_W'(cnt_q), stat_q, res_q.wt, res_q.id};
				end
			end
			default: ;
		endcase
	end

	`BMHQ_ASSERT(a_cnt_le_cap, cnt_q <= CAP_C, "entry count above capacity")
	`BMHQ_ASSERT_IMPL(a_hole_in_heap, state_q == FSM_UP_RD || state_q == FSM_DN_RD, XW'(hole_q) < cnt_x, "sift position outside heap")
	`BMHQ_ASSERT_IMPL(a_result_from_done, $rose(out_vld_q), $past(state_q) == FSM_DONE, "result loaded outside done")
	`BMHQ_ASSERT_IMPL(a_cnt_change_src, cnt_q != $past(cnt_q), $past(state_q) == FSM_IDLE || $past(state_q) == FSM_SRCH, "count changed mid sift")

endmodule

`default_nettype wire
